@@ rtl/core/vsct_pkg.sv @@
// Shared types and codes for the value slot change tracker.
// No dependencies; vsct_ctrl, vsct_datapath, the top level and vsct_checker import it.
package vsct_pkg;

	localparam logic [2:0] OP_UPDATE     = 3'd0;
	localparam logic [2:0] OP_MARK       = 3'd1;
	localparam logic [2:0] OP_READ       = 3'd2;
	localparam logic [2:0] OP_CONNECT    = 3'd3;
	localparam logic [2:0] OP_DISCONNECT = 3'd4;
	localparam logic [2:0] OP_DISABLE    = 3'd5;
	localparam logic [2:0] OP_HEALTH     = 3'd6;

	localparam logic [1:0] KIND_BOOL   = 2'd0;
	localparam logic [1:0] KIND_INT    = 2'd1;
	localparam logic [1:0] KIND_DOUBLE = 2'd2;
	localparam logic [1:0] KIND_NONE   = 2'd3;

	localparam logic [1:0] ST_GOOD      = 2'd0;
	localparam logic [1:0] ST_UNCERTAIN = 2'd1;
	localparam logic [1:0] ST_WAITING   = 2'd2;
	localparam logic [1:0] ST_OUT_OF_SV = 2'd3;

	localparam logic [1:0] LINK_CONNECTED    = 2'd1;
	localparam logic [1:0] LINK_DISCONNECTED = 2'd2;
	localparam logic [1:0] LINK_DISABLED     = 2'd3;

	localparam logic [1:0] CFG_SLOT_COUNT  = 2'd0;
	localparam logic [1:0] CFG_ENABLE_MASK = 2'd1;
	localparam logic [1:0] CFG_KIND_MAP    = 2'd2;

	localparam int CFG_DATA_W = 32;
	localparam int HW_SLOTS   = 16;

	typedef struct packed {
		logic [2:0]         operation;
		logic [7:0]         slot;
		logic [63:0]        value_bits;
		logic [1:0]         value_kind;
		logic signed [63:0] timestamp;
	} req_t;

	typedef struct packed {
		logic               ok;
		logic [63:0]        value_out;
		logic [1:0]         kind_out;
		logic [1:0]         status_out;
		logic signed [63:0] stamp_out;
		logic [31:0]        sequence_out;
		logic               has_value_out;
		logic [1:0]         link_state;
		logic [31:0]        failure_count;
		logic signed [63:0] last_good_time;
	} rsp_t;

	typedef struct packed {
		logic capture;
		logic commit;
	} ctrl_cmd_t;

endpackage

@@ rtl/core/vsct_req_if.sv @@
// Request channel of the value slot change tracker: valid/ready plus payload.
// No dependencies.
interface vsct_req_if;
	logic               valid;
	logic               ready;
	logic [2:0]         operation;
	logic [7:0]         slot;
	logic [63:0]        value_bits;
	logic [1:0]         value_kind;
	logic signed [63:0] timestamp;

	modport source(output valid, operation, slot, value_bits, value_kind, timestamp,
		input ready);
	modport sink(input valid, operation, slot, value_bits, value_kind, timestamp,
		output ready);
endinterface

@@ rtl/core/vsct_rsp_if.sv @@
// Response channel of the value slot change tracker: valid/ready plus payload.
// No dependencies.
interface vsct_rsp_if;
	logic               valid;
	logic               ready;
	logic               ok;
	logic [63:0]        value_out;
	logic [1:0]         kind_out;
	logic [1:0]         status_out;
	logic signed [63:0] stamp_out;
	logic [31:0]        sequence_out;
	logic               has_value_out;
	logic [1:0]         link_state;
	logic [31:0]        failure_count;
	logic signed [63:0] last_good_time;

	modport source(output valid, ok, value_out, kind_out, status_out, stamp_out,
		sequence_out, has_value_out, link_state, failure_count, last_good_time,
		input ready);
	modport sink(input valid, ok, value_out, kind_out, status_out, stamp_out,
		sequence_out, has_value_out, link_state, failure_count, last_good_time,
		output ready);
endinterface

@@ rtl/core/vsct_ctrl.sv @@
// Controller of the value slot change tracker: request/response handshake
// and read-then-write sequencing. Depends on vsct_pkg.
module vsct_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output vsct_pkg::ctrl_cmd_t cmd
);
	import vsct_pkg::*;

	typedef enum logic {
		S_IDLE,
		S_EXEC
	} state_t;

	state_t state_q;
	logic   ready_q;
	logic   valid_q;

	assign cmd.capture = req_valid && ready_q;
	assign cmd.commit  = (state_q == S_EXEC) && (!valid_q || rsp_ready);
	assign req_ready   = ready_q;
	assign rsp_valid   = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ready_q <= 1'b1;
			valid_q <= 1'b0;
		end else begin
			if (cmd.commit) begin
				valid_q <= 1'b1;
			end else if (rsp_ready) begin
				valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (cmd.capture) begin
						state_q <= S_EXEC;
						ready_q <= 1'b0;
					end
				end
				S_EXEC: begin
					if (cmd.commit) begin
						state_q <= S_IDLE;
						ready_q <= 1'b1;
					end
				end
				default: begin
					state_q <= S_IDLE;
					ready_q <= 1'b1;
				end
			endcase
		end
	end
endmodule

@@ rtl/core/vsct_datapath.sv @@
// Datapath of the value slot change tracker: configuration registers, slot
// memory with valid bits, change detection, health record, response register.
// Depends on vsct_pkg.
module vsct_datapath #(
	parameter int SLOT_COUNT_MAX = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  vsct_pkg::ctrl_cmd_t                 cmd,
	input  vsct_pkg::req_t                      req,
	input  logic                                cfg_we,
	input  logic [1:0]                          cfg_index,
	input  logic [vsct_pkg::CFG_DATA_W-1:0]     cfg_data,
	output vsct_pkg::rsp_t                      rsp
);
	import vsct_pkg::*;

	localparam int SW = (SLOT_COUNT_MAX > 1) ? $clog2(SLOT_COUNT_MAX) : 1;

	logic [4:0]  slot_count_q;
	logic [15:0] enable_mask_q;
	logic [31:0] kind_map_q;

	logic [63:0] mem_value [SLOT_COUNT_MAX];
	logic [63:0] mem_stamp [SLOT_COUNT_MAX];
	logic [31:0] mem_seq   [SLOT_COUNT_MAX];
	logic [SLOT_COUNT_MAX-1:0] has_q;
	logic [SLOT_COUNT_MAX-1:0] unc_q;

	logic [1:0]  link_q;
	logic [31:0] fail_q;
	logic [63:0] last_q;

	// request decode, captured on accept
	logic [2:0]  op_s1;
	logic [SW-1:0] addr_s1;
	logic [63:0] val_s1;
	logic [1:0]  vkind_s1;
	logic [63:0] ts_s1;
	logic        valid_s1;
	logic        enabled_s1;
	logic [1:0]  kind_s1;
	logic        has_s1;
	logic        unc_s1;
	logic [63:0] rd_value_q;
	logic [63:0] rd_stamp_q;
	logic [31:0] rd_seq_q;

	logic [SW-1:0] req_addr;
	logic          req_valid_slot;
	logic          req_in_hw;

	assign req_addr       = req.slot[SW-1:0];
	assign req_in_hw      = req.slot < 8'(HW_SLOTS);
	assign req_valid_slot = (req.slot < 8'(slot_count_q))
		&& ({1'b0, req.slot} < 9'(SLOT_COUNT_MAX));

	function automatic logic is_nan(input logic [63:0] v);
		return (v[62:52] == 11'h7FF) && (v[51:0] != 52'd0);
	endfunction

	logic [63:0] cur_value, cur_stamp, new_value, new_stamp, new_nv, new_last;
	logic [31:0] cur_seq, new_seq, new_fail;
	logic [1:0]  cur_status, new_status, new_link;
	logic        new_has, new_unc, ok, same, vchg, chg, show;

	always_comb begin
		cur_value = has_s1 ? rd_value_q : '0;
		cur_stamp = has_s1 ? rd_stamp_q : '0;
		cur_seq   = has_s1 ? rd_seq_q : '0;
		cur_status = has_s1 ? (unc_s1 ? ST_UNCERTAIN : ST_GOOD)
			: (enabled_s1 ? ST_WAITING : ST_OUT_OF_SV);
		new_nv = (kind_s1 == KIND_BOOL) ? {63'd0, val_s1[0]} : val_s1;
		if ((kind_s1 == KIND_DOUBLE) && (is_nan(cur_value) || is_nan(new_nv))) begin
			same = is_nan(cur_value) && is_nan(new_nv);
		end else if ((kind_s1 == KIND_DOUBLE)
			&& (((cur_value | new_nv) & 64'h7FFF_FFFF_FFFF_FFFF) == 64'd0)) begin
			same = 1'b1;
		end else begin
			same = (cur_value == new_nv);
		end
		vchg = !has_s1 || !same;
		chg  = vchg || (cur_status != ST_GOOD);

		new_value = cur_value;
		new_stamp = cur_stamp;
		new_seq   = cur_seq;
		new_has   = has_s1;
		new_unc   = unc_s1;
		new_link  = link_q;
		new_fail  = fail_q;
		new_last  = last_q;
		ok        = 1'b0;
		show      = (op_s1 == OP_UPDATE || op_s1 == OP_MARK || op_s1 == OP_READ)
			&& valid_s1;

		unique case (op_s1)
			OP_UPDATE: begin
				if (valid_s1 && enabled_s1 && (kind_s1 != KIND_NONE)
					&& (vkind_s1 == kind_s1)) begin
					if (vchg) begin
						new_value = new_nv;
					end
					new_unc   = 1'b0;
					new_has   = 1'b1;
					new_stamp = ts_s1;
					if (chg) begin
						new_seq = cur_seq + 32'd1;
					end
					new_last = ts_s1;
					new_fail = '0;
					ok       = chg;
				end
			end
			OP_MARK: begin
				if (valid_s1 && enabled_s1 && has_s1 && !unc_s1) begin
					new_unc = 1'b1;
					new_seq = cur_seq + 32'd1;
					ok      = 1'b1;
				end
			end
			OP_READ: begin
				ok = valid_s1;
			end
			OP_CONNECT: begin
				new_link = LINK_CONNECTED;
				new_fail = '0;
				ok       = 1'b1;
			end
			OP_DISCONNECT: begin
				if (link_q != LINK_DISCONNECTED) begin
					new_link = LINK_DISCONNECTED;
					if (fail_q != 32'hFFFF_FFFF) begin
						new_fail = fail_q + 32'd1;
					end
				end
				ok = 1'b1;
			end
			OP_DISABLE: begin
				new_link = LINK_DISABLED;
				new_fail = '0;
				ok       = 1'b1;
			end
			OP_HEALTH: begin
				ok = 1'b1;
			end
			default: begin
				ok = 1'b0;
			end
		endcase

		new_status = new_has ? (new_unc ? ST_UNCERTAIN : ST_GOOD)
			: (enabled_s1 ? ST_WAITING : ST_OUT_OF_SV);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_count_q  <= '0;
			enable_mask_q <= '0;
			kind_map_q    <= '0;
			has_q         <= '0;
			unc_q         <= '0;
			link_q        <= '0;
			fail_q        <= '0;
			last_q        <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_SLOT_COUNT:  slot_count_q  <= cfg_data[4:0];
					CFG_ENABLE_MASK: enable_mask_q <= cfg_data[15:0];
					CFG_KIND_MAP:    kind_map_q    <= cfg_data[31:0];
					default: ;
				endcase
			end
			if (cmd.commit) begin
				link_q <= new_link;
				fail_q <= new_fail;
				last_q <= new_last;
				if (show) begin
					has_q[addr_s1] <= new_has;
					unc_q[addr_s1] <= new_unc;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_s1      <= req.operation;
			addr_s1    <= req_addr;
			val_s1     <= req.value_bits;
			vkind_s1   <= req.value_kind;
			ts_s1      <= req.timestamp;
			valid_s1   <= req_valid_slot;
			enabled_s1 <= req_in_hw && enable_mask_q[req.slot[3:0]];
			kind_s1    <= req_in_hw ? kind_map_q[{req.slot[3:0], 1'b0} +: 2] : KIND_BOOL;
			has_s1     <= req_valid_slot & has_q[req_addr];
			unc_s1     <= req_valid_slot & unc_q[req_addr];
			rd_value_q <= mem_value[req_addr];
			rd_stamp_q <= mem_stamp[req_addr];
			rd_seq_q   <= mem_seq[req_addr];
		end
		if (cmd.commit && show) begin
			mem_value[addr_s1] <= new_value;
			mem_stamp[addr_s1] <= new_stamp;
			mem_seq[addr_s1]   <= new_seq;
		end
		if (cmd.commit) begin
			rsp.ok             <= ok;
			rsp.value_out      <= show ? new_value : '0;
			rsp.kind_out       <= show ? kind_s1 : '0;
			rsp.status_out     <= show ? new_status : '0;
			rsp.stamp_out      <= show ? new_stamp : '0;
			rsp.sequence_out   <= show ? new_seq : '0;
			rsp.has_value_out  <= show && new_has;
			rsp.link_state     <= new_link;
			rsp.failure_count  <= new_fail;
			rsp.last_good_time <= new_last;
		end
	end
endmodule

@@ rtl/core/value_slot_change_tracker.sv @@
// Top level of the value slot change tracker: controller plus datapath.
// Depends on vsct_pkg, vsct_req_if, vsct_rsp_if, vsct_ctrl, vsct_datapath.
//
// Usage:
//   req carries one operation per request (update, mark unavailable, read
//   slot, connected, disconnected, disabled, read health); rsp returns one
//   result per request with the slot snapshot and the source health.
//   cfg_we/cfg_index/cfg_data write slot_count (0), slot_enable_mask (1) and
//   slot_kind_map (2); write only while no request is in flight.
//   A request is captured on acceptance and its result registered at commit;
//   a new one is accepted only after the slot memory read-modify-write of
//   the last: the entry is read at capture and written back at commit.
//   The result sits in an output register; req.ready stays up while it waits,
//   and a following request is held before commit until rsp drains.
//   Reset clears configuration, health and the per-slot valid bits at once;
//   a slot without a value reads as all zero, so no clearing pass is needed.
module value_slot_change_tracker #(
	parameter int SLOT_COUNT_MAX = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	vsct_req_if.sink                        req,
	vsct_rsp_if.source                      rsp,
	input  logic                            cfg_we,
	input  logic [1:0]                      cfg_index,
	input  logic [vsct_pkg::CFG_DATA_W-1:0] cfg_data
);
	import vsct_pkg::*;

	ctrl_cmd_t cmd;
	req_t      req_pl;
	rsp_t      rsp_pl;

	assign req_pl.operation  = req.operation;
	assign req_pl.slot       = req.slot;
	assign req_pl.value_bits = req.value_bits;
	assign req_pl.value_kind = req.value_kind;
	assign req_pl.timestamp  = req.timestamp;

	assign rsp.ok             = rsp_pl.ok;
	assign rsp.value_out      = rsp_pl.value_out;
	assign rsp.kind_out       = rsp_pl.kind_out;
	assign rsp.status_out     = rsp_pl.status_out;
	assign rsp.stamp_out      = rsp_pl.stamp_out;
	assign rsp.sequence_out   = rsp_pl.sequence_out;
	assign rsp.has_value_out  = rsp_pl.has_value_out;
	assign rsp.link_state     = rsp_pl.link_state;
	assign rsp.failure_count  = rsp_pl.failure_count;
	assign rsp.last_good_time = rsp_pl.last_good_time;

	vsct_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.cmd       (cmd)
	);

	vsct_datapath #(
		.SLOT_COUNT_MAX (SLOT_COUNT_MAX)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.req       (req_pl),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.rsp       (rsp_pl)
	);
endmodule

@@ rtl/core/vsct_checker.sv @@
// Port-level checks for value_slot_change_tracker, attached by bind.
// Depends on vsct_pkg and the top level's interface ports.
module vsct_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_ready,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic        rsp_ok,
	input logic [63:0] rsp_value,
	input logic [63:0] rsp_stamp,
	input logic [31:0] rsp_seq,
	input logic [1:0]  rsp_status,
	input logic        rsp_has
);
	import vsct_pkg::*;

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_ok)
			&& $stable(rsp_value) && $stable(rsp_seq))
		else $error("response changed while stalled");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request accepted while another is in flight");

	a_unvalued_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_has |-> rsp_value == 64'd0 && rsp_stamp == 64'd0
			&& rsp_seq == 32'd0)
		else $error("slot without value reports nonzero snapshot");

	a_valued_status: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_has |-> rsp_status == ST_GOOD || rsp_status == ST_UNCERTAIN)
		else $error("valued slot reports waiting or out of service");
endmodule

bind value_slot_change_tracker vsct_checker u_vsct_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_valid  (req.valid),
	.req_ready  (req.ready),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.rsp_ok     (rsp.ok),
	.rsp_value  (rsp.value_out),
	.rsp_stamp  (rsp.stamp_out),
	.rsp_seq    (rsp.sequence_out),
	.rsp_status (rsp.status_out),
	.rsp_has    (rsp.has_value_out)
);

@@ tb/sv/value_slot_change_tracker_test.sv @@
`timescale 1ns / 1ps
// Self-checking bench for value_slot_change_tracker: directed and random requests,
// a behavioral slot table predicting every result, random stalls on both channels.
// Depends on vsct_pkg, vsct_req_if, vsct_rsp_if and the tracker RTL.
module value_slot_change_tracker_test;
	import vsct_pkg::*;

	localparam logic [2:0] OP_SPARE    = 3'd7;
	localparam int         CYCLE_LIMIT = 200000;
	localparam int         LONG_HOLD   = 400;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [31:0] cfg_data;

	vsct_req_if req();
	vsct_rsp_if rsp();

	value_slot_change_tracker #(.SLOT_COUNT_MAX(16)) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// slot table mirror
	logic [63:0] tbl_value    [HW_SLOTS];
	logic [63:0] tbl_stamp    [HW_SLOTS];
	logic [31:0] tbl_sequence [HW_SLOTS];
	logic        tbl_valued   [HW_SLOTS];
	logic        tbl_uncertain[HW_SLOTS];
	logic [1:0]  link;
	logic [31:0] fail_run;
	logic [63:0] last_good;
	logic [4:0]  cfg_count;
	logic [15:0] cfg_mask;
	logic [31:0] cfg_kinds;

	req_t request_q[$];
	rsp_t snapshot_q[$];
	int   mismatches;
	int   cycle_count;
	int   hold_left;
	logic hold_request;
	logic calm;
	logic req_taken;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic logic slot_on(logic [3:0] s);
		return cfg_mask[s];
	endfunction

	function automatic logic [1:0] slot_status(logic [3:0] s);
		if (tbl_valued[s])
			return tbl_uncertain[s] ? ST_UNCERTAIN : ST_GOOD;
		return slot_on(s) ? ST_WAITING : ST_OUT_OF_SV;
	endfunction

	function automatic logic is_nan(logic [63:0] v);
		return v[62:52] == 11'h7FF && v[51:0] != 52'd0;
	endfunction

	function automatic logic same_value(logic [1:0] k, logic [63:0] a, logic [63:0] b);
		if (k == KIND_DOUBLE) begin
			if (is_nan(a) || is_nan(b))
				return is_nan(a) && is_nan(b);
			if ((a[62:0] | b[62:0]) == 63'd0)
				return 1'b1;
		end
		return a == b;
	endfunction

	function automatic rsp_t apply_request(req_t r);
		rsp_t        o;
		logic [3:0]  s;
		logic [1:0]  k;
		logic [63:0] nv;
		logic        vchg;
		logic        chg;
		o = '0;
		s = r.slot[3:0];
		if (r.operation <= OP_READ && r.slot < cfg_count && r.slot < HW_SLOTS) begin
			k = cfg_kinds[{s, 1'b0} +: 2];
			if (r.operation == OP_UPDATE) begin
				if (slot_on(s) && k != KIND_NONE && r.value_kind == k) begin
					nv = (k == KIND_BOOL) ? {63'd0, r.value_bits[0]} : r.value_bits;
					vchg = !tbl_valued[s] || !same_value(k, tbl_value[s], nv);
					chg = vchg || slot_status(s) != ST_GOOD;
					if (vchg)
						tbl_value[s] = nv;
					tbl_uncertain[s] = 1'b0;
					tbl_valued[s] = 1'b1;
					tbl_stamp[s] = r.timestamp;
					if (chg)
						tbl_sequence[s] = tbl_sequence[s] + 32'd1;
					last_good = r.timestamp;
					fail_run = '0;
					o.ok = chg;
				end
			end else if (r.operation == OP_MARK) begin
				if (slot_on(s) && tbl_valued[s] && !tbl_uncertain[s]) begin
					tbl_uncertain[s] = 1'b1;
					tbl_sequence[s] = tbl_sequence[s] + 32'd1;
					o.ok = 1'b1;
				end
			end else begin
				o.ok = 1'b1;
			end
			o.value_out = tbl_value[s];
			o.kind_out = k;
			o.status_out = slot_status(s);
			o.stamp_out = tbl_stamp[s];
			o.sequence_out = tbl_sequence[s];
			o.has_value_out = tbl_valued[s];
		end else begin
			case (r.operation)
				OP_CONNECT: begin
					link = LINK_CONNECTED;
					fail_run = '0;
					o.ok = 1'b1;
				end
				OP_DISCONNECT: begin
					if (link != LINK_DISCONNECTED) begin
						link = LINK_DISCONNECTED;
						if (fail_run != 32'hFFFF_FFFF)
							fail_run = fail_run + 32'd1;
					end
					o.ok = 1'b1;
				end
				OP_DISABLE: begin
					link = LINK_DISABLED;
					fail_run = '0;
					o.ok = 1'b1;
				end
				OP_HEALTH: o.ok = 1'b1;
				default: ;
			endcase
		end
		o.link_state = link;
		o.failure_count = fail_run;
		o.last_good_time = last_good;
		return o;
	endfunction

	function automatic req_t make_request(logic [2:0] op, logic [7:0] slot, logic [63:0] value,
			logic [1:0] kind, logic [63:0] stamp);
		req_t r;
		r.operation = op;
		r.slot = slot;
		r.value_bits = value;
		r.value_kind = kind;
		r.timestamp = stamp;
		return r;
	endfunction

	function automatic req_t random_request();
		req_t        r;
		logic [1:0]  k;
		logic        sgn;
		logic [51:0] man;
		int          pick;
		pick = $urandom_range(0, 99);
		sgn = 1'($urandom_range(0, 1));
		man = 52'({$urandom, $urandom});
		if (man == 52'd0)
			man = 52'd1;
		if (cfg_count != 0 && $urandom_range(0, 9) != 0)
			r.slot = 8'($urandom_range(0, cfg_count - 1));
		else
			r.slot = 8'($urandom_range(0, 255));
		k = (r.slot < HW_SLOTS) ? cfg_kinds[{r.slot[3:0], 1'b0} +: 2] : KIND_BOOL;
		r.value_kind = ($urandom_range(0, 9) == 0) ? 2'($urandom_range(0, 3)) : k;
		case ($urandom_range(0, 5))
			0: r.value_bits = {$urandom, $urandom};
			1: r.value_bits = 64'($urandom_range(0, 3));
			2: r.value_bits = {sgn, 63'd0};
			3: r.value_bits = {sgn, 11'h7FF, man};
			4: r.value_bits = {sgn, 11'h7FF, 52'd0};
			default: r.value_bits = {sgn, 11'h3FF, 52'd0};
		endcase
		if ($urandom_range(0, 3) == 0)
			r.timestamp = {$urandom, $urandom};
		else
			r.timestamp = 64'($urandom_range(0, 1000));
		if (pick < 48)
			r.operation = OP_UPDATE;
		else if (pick < 60)
			r.operation = OP_MARK;
		else if (pick < 72)
			r.operation = OP_READ;
		else if (pick < 77)
			r.operation = OP_CONNECT;
		else if (pick < 84)
			r.operation = OP_DISCONNECT;
		else if (pick < 88)
			r.operation = OP_DISABLE;
		else if (pick < 93)
			r.operation = OP_HEALTH;
		else begin
			r.operation = 3'($urandom_range(0, 7));
			r.slot = 8'($urandom_range(0, 255));
			r.value_kind = 2'($urandom_range(0, 3));
			r.value_bits = {$urandom, $urandom};
		end
		return r;
	endfunction

	task automatic add_request(req_t r);
		request_q.insert(request_q.size(), r);
	endtask

	task automatic settle();
		while (request_q.size() != 0 || snapshot_q.size() != 0 || req.valid)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [31:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		case (idx)
			CFG_SLOT_COUNT:  cfg_count = data[4:0];
			CFG_ENABLE_MASK: cfg_mask = data[15:0];
			CFG_KIND_MAP:    cfg_kinds = data;
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic configure(logic [4:0] count, logic [15:0] mask, logic [31:0] kinds);
		settle();
		write_reg(CFG_SLOT_COUNT, {27'd0, count});
		write_reg(CFG_ENABLE_MASK, {16'd0, mask});
		write_reg(CFG_KIND_MAP, kinds);
	endtask

	task automatic queue_random(int n);
		repeat (n) add_request(random_request());
	endtask

	task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: %s mismatch: expected %h, got %h", $realtime, name, want, got);
		end
	endtask

	// request driver
	always @(negedge clk) begin
		if (!arst_n) begin
			req.valid <= 1'b0;
		end else if (req.valid && !req_taken) begin
		end else if (request_q.size() != 0 && (calm || $urandom_range(0, 99) >= 13)) begin
			req.valid <= 1'b1;
			req.operation <= request_q[0].operation;
			req.slot <= request_q[0].slot;
			req.value_bits <= request_q[0].value_bits;
			req.value_kind <= request_q[0].value_kind;
			req.timestamp <= request_q[0].timestamp;
		end else begin
			req.valid <= 1'b0;
		end
	end

	always @(posedge clk) begin
		req_taken <= req.valid && req.ready;
		if (arst_n && req.valid && req.ready) begin
			snapshot_q.insert(snapshot_q.size(), apply_request(make_request(req.operation,
				req.slot, req.value_bits, req.value_kind, req.timestamp)));
			void'(request_q.pop_front());
		end
	end

	// response ready, with an occasional long hold-off
	always @(negedge clk) begin
		if (hold_request) begin
			hold_left = LONG_HOLD;
			hold_request = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			rsp.ready <= 1'b0;
		end else begin
			rsp.ready <= calm || $urandom_range(0, 99) >= 13;
		end
	end

	// response monitor
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (snapshot_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: result with no request outstanding", $realtime);
			end else begin
				want = snapshot_q.pop_front();
				check_field("ok", want.ok, rsp.ok);
				check_field("value_out", want.value_out, rsp.value_out);
				check_field("kind_out", want.kind_out, rsp.kind_out);
				check_field("status_out", want.status_out, rsp.status_out);
				check_field("stamp_out", want.stamp_out, rsp.stamp_out);
				check_field("sequence_out", want.sequence_out, rsp.sequence_out);
				check_field("has_value_out", want.has_value_out, rsp.has_value_out);
				check_field("link_state", want.link_state, rsp.link_state);
				check_field("failure_count", want.failure_count, rsp.failure_count);
				check_field("last_good_time", want.last_good_time, rsp.last_good_time);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		for (int i = 0; i < HW_SLOTS; i++) begin
			tbl_value[i] = '0;
			tbl_stamp[i] = '0;
			tbl_sequence[i] = '0;
			tbl_valued[i] = 1'b0;
			tbl_uncertain[i] = 1'b0;
		end
		link = '0;
		fail_run = '0;
		last_good = '0;
		cfg_count = '0;
		cfg_mask = '0;
		cfg_kinds = '0;
		mismatches = 0;
		cycle_count = 0;
		hold_left = 0;
		hold_request = 1'b0;
		calm = 1'b0;
		req_taken = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		req.valid = 1'b0;
		req.operation = '0;
		req.slot = '0;
		req.value_bits = '0;
		req.value_kind = '0;
		req.timestamp = '0;
		rsp.ready = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// registers still at reset: no slot is valid
		add_request(make_request(OP_READ, 8'd0, '0, KIND_BOOL, '0));
		add_request(make_request(OP_SPARE, 8'd3, '1, KIND_NONE, '1));

		// bool 0-3, int 4-7, double 8-11, unusable kind 12-15
		configure(5'd16, 16'hFFFF, 32'hFFAA_5500);
		calm = 1'b1;
		add_request(make_request(OP_READ, 8'd15, '0, KIND_BOOL, '0));
		add_request(make_request(OP_UPDATE, 8'd0, '1, KIND_BOOL, 64'd1));
		add_request(make_request(OP_UPDATE, 8'd0, 64'h3, KIND_BOOL, 64'd2));
		add_request(make_request(OP_UPDATE, 8'd4, 64'h8000_0000_0000_0000, KIND_INT,
			64'h8000_0000_0000_0000));
		add_request(make_request(OP_UPDATE, 8'd4, 64'h7FFF_FFFF_FFFF_FFFF, KIND_INT,
			64'h7FFF_FFFF_FFFF_FFFF));
		add_request(make_request(OP_UPDATE, 8'd8, 64'h0, KIND_DOUBLE, 64'd5));
		add_request(make_request(OP_UPDATE, 8'd8, 64'h8000_0000_0000_0000, KIND_DOUBLE,
			64'd6));
		add_request(make_request(OP_UPDATE, 8'd8, 64'h7FF8_0000_0000_0000, KIND_DOUBLE,
			64'd7));
		add_request(make_request(OP_UPDATE, 8'd8, 64'hFFF0_0000_0000_0001, KIND_DOUBLE,
			64'd8));
		add_request(make_request(OP_UPDATE, 8'd8, 64'h7FF0_0000_0000_0000, KIND_DOUBLE,
			64'd9));
		add_request(make_request(OP_UPDATE, 8'd0, 64'h0, KIND_INT, 64'd10));
		add_request(make_request(OP_UPDATE, 8'd12, 64'h1, KIND_NONE, 64'd11));
		add_request(make_request(OP_MARK, 8'd0, '0, KIND_BOOL, '0));
		add_request(make_request(OP_MARK, 8'd0, '0, KIND_BOOL, '0));
		add_request(make_request(OP_UPDATE, 8'd0, 64'h1, KIND_BOOL, 64'd12));
		add_request(make_request(OP_UPDATE, 8'd255, 64'h1, KIND_BOOL, 64'd13));
		add_request(make_request(OP_MARK, 8'd5, '0, KIND_INT, '0));
		add_request(make_request(OP_DISCONNECT, 8'd0, '0, KIND_BOOL, '0));
		add_request(make_request(OP_DISCONNECT, 8'd0, '0, KIND_BOOL, '0));
		add_request(make_request(OP_CONNECT, 8'd0, '0, KIND_BOOL, '0));
		add_request(make_request(OP_DISCONNECT, 8'd0, '0, KIND_BOOL, '0));
		add_request(make_request(OP_DISABLE, 8'd0, '0, KIND_BOOL, '0));
		add_request(make_request(OP_HEALTH, 8'd0, '0, KIND_BOOL, '0));
		queue_random(200);
		settle();
		calm = 1'b0;

		configure(5'($urandom_range(1, 16)), 16'($urandom), $urandom);
		hold_request = 1'b1;
		queue_random(200);

		configure(5'd16, 16'h0000, 32'h0000_0000);
		queue_random(100);

		configure(5'd0, 16'hFFFF, 32'hFFFF_FFFF);
		queue_random(60);

		configure(5'd16, 16'hFFFF, 32'hAAAA_AAAA);
		queue_random(200);

		configure(5'd1, 16'h0001, $urandom);
		queue_random(100);

		configure(5'd16, 16'($urandom), $urandom);
		queue_random(250);

		settle();
		repeat (10) @(posedge clk);
		if (mismatches == 0 && snapshot_q.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/core/vsct_pkg.sv
rtl/core/vsct_req_if.sv
rtl/core/vsct_rsp_if.sv
rtl/core/vsct_ctrl.sv
rtl/core/vsct_datapath.sv
rtl/core/value_slot_change_tracker.sv
rtl/core/vsct_checker.sv
tb/sv/value_slot_change_tracker_test.sv
